// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms; reset disables checking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// overlapping implication
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== design/tewa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewa_pkg
// Types and constants of the threshold event window averager.
// ----------------------------------------------------------------------------
package tewa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int IDX_W       = 12;
   localparam int SUM_W       = 28;
   localparam int MAX_SAMPLES = 2048;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic signed [SAMPLE_W-1:0] GAS_THRESHOLD_RST  = 16'sd3200;
   localparam logic signed [SAMPLE_W-1:0] TEMP_THRESHOLD_RST = 16'sd1520;

   typedef enum logic [0:0] {
      CSR_GAS_THRESHOLD  = 1'b0,
      CSR_TEMP_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] temp_sample;
      logic signed [SAMPLE_W-1:0] gas_sample;
      logic                       last_sample;
   } req_item_type;

   typedef struct packed {
      logic                       event_found;
      logic        [IDX_W-1:0]    start_index;
      logic        [IDX_W-1:0]    end_index;
      logic signed [SAMPLE_W-1:0] mean_temp;
      logic signed [SAMPLE_W-1:0] mean_gas;
      logic                       overrun;
   } rsp_item_type;

   // summary of a data set as seen with its final sample included
   typedef struct packed {
      logic                     found;
      logic        [IDX_W-1:0]  start_idx;
      logic        [IDX_W-1:0]  end_idx;
      logic        [IDX_W-1:0]  len;
      logic signed [SUM_W-1:0]  temp_sum;
      logic signed [SUM_W-1:0]  gas_sum;
      logic                     overrun;
   } set_summary_type;

endpackage

// ===== design/tewa_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewa_accum
// Event tracker: follows the event phase, indices and channel sums per item.
// ----------------------------------------------------------------------------
module tewa_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  tewa_pkg::req_item_type               item,
   input  logic signed [tewa_pkg::SAMPLE_W-1:0] gas_threshold,
   input  logic signed [tewa_pkg::SAMPLE_W-1:0] temp_threshold,
   output tewa_pkg::set_summary_type            summary
);

   typedef enum logic [2:0] {
      PH_WAIT   = 3'b001,
      PH_ACTIVE = 3'b010,
      PH_ENDED  = 3'b100
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic        [tewa_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic        [tewa_pkg::IDX_W-1:0]      start_ff, start_in;
   logic        [tewa_pkg::IDX_W-1:0]      end_ff, end_in;
   logic signed [tewa_pkg::SUM_W-1:0]      tsum_ff, tsum_in;
   logic signed [tewa_pkg::SUM_W-1:0]      gsum_ff, gsum_in;
   logic                                   ovf_ff, ovf_in;

   logic signed [tewa_pkg::SUM_W-1:0]      t_ext;
   logic signed [tewa_pkg::SUM_W-1:0]      g_ext;
   logic                                   hit;
   logic                                   quiet;
   logic                                   found;
   logic        [tewa_pkg::IDX_W-1:0]      s_idx;
   logic        [tewa_pkg::IDX_W-1:0]      e_idx;

   assign t_ext = tewa_pkg::SUM_W'(item.temp_sample);
   assign g_ext = tewa_pkg::SUM_W'(item.gas_sample);
   assign hit   = (item.gas_sample > gas_threshold) || (item.temp_sample > temp_threshold);
   assign quiet = (item.gas_sample < gas_threshold) && (item.temp_sample < temp_threshold);

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      end_in   = end_ff;
      tsum_in  = tsum_ff;
      gsum_in  = gsum_ff;
      ovf_in   = ovf_ff;
      if (idx_ff < tewa_pkg::IDX_W'(tewa_pkg::MAX_SAMPLES)) begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (hit) begin
                  start_in = idx_ff;
                  phase_in = PH_ACTIVE;
                  tsum_in  = tsum_ff + t_ext;
                  gsum_in  = gsum_ff + g_ext;
               end
            end
            PH_ACTIVE: begin
               if (quiet) begin
                  end_in   = idx_ff;
                  phase_in = PH_ENDED;
               end else begin
                  tsum_in  = tsum_ff + t_ext;
                  gsum_in  = gsum_ff + g_ext;
               end
            end
            PH_ENDED: begin
            end
            default: begin
            end
         endcase
         idx_in = idx_ff + 1'b1;
      end else begin
         ovf_in = 1'b1;
      end
   end

   // event still open at the final item: it ends at the sample count
   assign found = (phase_in != PH_WAIT);
   assign s_idx = found ? start_in : idx_in;
   assign e_idx = (phase_in == PH_ENDED) ? end_in : idx_in;

   always_comb begin
      summary.found     = found;
      summary.start_idx = s_idx;
      summary.end_idx   = e_idx;
      summary.len       = e_idx - s_idx;
      summary.temp_sum  = tsum_in;
      summary.gas_sum   = gsum_in;
      summary.overrun   = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         idx_ff   <= '0;
         start_ff <= '0;
         end_ff   <= '0;
         tsum_ff  <= '0;
         gsum_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         if (item.last_sample) begin
            phase_ff <= PH_WAIT;
            idx_ff   <= '0;
            start_ff <= '0;
            end_ff   <= '0;
            tsum_ff  <= '0;
            gsum_ff  <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            start_ff <= start_in;
            end_ff   <= end_in;
            tsum_ff  <= tsum_in;
            gsum_ff  <= gsum_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

endmodule

// ===== design/tewa_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tewa_divider
// Shared radix-2 restoring divider; divides both channel sums in turn.
// ----------------------------------------------------------------------------
module tewa_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [tewa_pkg::SUM_W-1:0]    dividend_a,
   input  logic signed [tewa_pkg::SUM_W-1:0]    dividend_b,
   input  logic        [tewa_pkg::IDX_W-1:0]    divisor,
   output logic                                 busy,
   output logic                                 done,
   output logic signed [tewa_pkg::SAMPLE_W-1:0] quot_a,
   output logic signed [tewa_pkg::SAMPLE_W-1:0] quot_b
);

   logic                                   busy_ff;
   logic                                   done_ff;
   logic                                   chan_ff;
   logic        [tewa_pkg::STEP_W-1:0]     cnt_ff;
   logic        [tewa_pkg::IDX_W-1:0]      rem_ff;
   logic        [tewa_pkg::SUM_W-1:0]      quo_ff;
   logic                                   neg_ff;
   logic signed [tewa_pkg::SUM_W-1:0]      hold_ff;
   logic        [tewa_pkg::IDX_W-1:0]      dvsr_ff;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   qa_ff;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   qb_ff;

   logic        [tewa_pkg::IDX_W:0]        shifted;
   logic        [tewa_pkg::IDX_W:0]        diff;
   logic                                   ge;
   logic        [tewa_pkg::IDX_W-1:0]      rem_step;
   logic        [tewa_pkg::SUM_W-1:0]      quo_step;
   logic        [tewa_pkg::SAMPLE_W-1:0]   qmag;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   qres;

   function automatic logic [tewa_pkg::SUM_W-1:0] magnitude(
      input logic signed [tewa_pkg::SUM_W-1:0] v
   );
      magnitude = v[tewa_pkg::SUM_W-1] ? tewa_pkg::SUM_W'(-v) : tewa_pkg::SUM_W'(v);
   endfunction

   assign shifted  = {rem_ff, quo_ff[tewa_pkg::SUM_W-1]};
   assign ge       = (shifted >= {1'b0, dvsr_ff});
   assign diff     = shifted - {1'b0, dvsr_ff};
   assign rem_step = ge ? diff[tewa_pkg::IDX_W-1:0] : shifted[tewa_pkg::IDX_W-1:0];
   assign quo_step = {quo_ff[tewa_pkg::SUM_W-2:0], ge};
   assign qmag     = quo_step[tewa_pkg::SAMPLE_W-1:0];
   assign qres     = neg_ff ? $signed(-qmag) : $signed(qmag);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         chan_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            chan_ff <= 1'b0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == tewa_pkg::STEP_W'(tewa_pkg::DIV_STEPS - 1)) begin
               cnt_ff <= '0;
               if (chan_ff) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  chan_ff <= 1'b1;
               end
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= magnitude(dividend_a);
         neg_ff  <= dividend_a[tewa_pkg::SUM_W-1];
         hold_ff <= dividend_b;
         dvsr_ff <= divisor;
      end else if (busy_ff) begin
         if (cnt_ff == tewa_pkg::STEP_W'(tewa_pkg::DIV_STEPS - 1)) begin
            rem_ff <= '0;
            if (chan_ff) begin
               qb_ff  <= qres;
               quo_ff <= quo_step;
            end else begin
               qa_ff  <= qres;
               quo_ff <= magnitude(hold_ff);
               neg_ff <= hold_ff[tewa_pkg::SUM_W-1];
            end
         end else begin
            rem_ff <= rem_step;
            quo_ff <= quo_step;
         end
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign quot_a = qa_ff;
   assign quot_b = qb_ff;

endmodule

// ===== design/threshold_event_window_averager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_event_window_averager_core
// Finds the threshold event in a sample set and reports its window and means.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one temperature/gas sample pair per item; last_sample closes a set.
//   rsp_*  : one result item per set, issued after the final sample.
//   csr_*  : threshold writes; write only while no set is in progress.
// Throughput: ordinary samples are taken one per cycle.
// Result path: the final sample of a set holds the input; when an event was
//   seen, both channel sums go through 28-step serial divisions in turn on
//   the shared divider, then the divide state is left and the result is loaded;
//   when none was, the result is loaded without a division.
// The result sits in an output register; if the receiver stalls, a further
//   finished result waits inside until that register is free, and no new
//   sample is taken meanwhile.
// Reset: thresholds return to 200.0 (gas) and 95.0 (temperature), the set
//   state clears and no result is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module threshold_event_window_averager_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  tewa_pkg::req_item_type               req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tewa_pkg::rsp_item_type               rsp_item,
   input  logic                                 csr_we,
   input  tewa_pkg::csr_index_type              csr_index,
   input  logic        [tewa_pkg::SAMPLE_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DIVIDE  = 3'b010,
      ST_PUBLISH = 3'b100
   } state_type;

   state_type                              state_ff, state_in;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   gas_thr_ff;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   temp_thr_ff;
   tewa_pkg::rsp_item_type                 pend_ff;
   logic                                   zero_avg_ff;
   tewa_pkg::rsp_item_type                 rsp_ff, rsp_in;
   logic                                   rsp_valid_ff;

   tewa_pkg::set_summary_type              summary;
   logic                                   accept;
   logic                                   last_acc;
   logic                                   need_div;
   logic                                   slot_free;
   logic                                   div_busy;
   logic                                   div_done;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   avg_t;
   logic signed [tewa_pkg::SAMPLE_W-1:0]   avg_g;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_acc  = accept && req_item.last_sample;
   assign need_div  = summary.found && (summary.len != '0);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   tewa_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .item           (req_item),
      .gas_threshold  (gas_thr_ff),
      .temp_threshold (temp_thr_ff),
      .summary        (summary)
   );

   tewa_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (last_acc && need_div),
      .dividend_a (summary.temp_sum),
      .dividend_b (summary.gas_sum),
      .divisor    (summary.len),
      .busy       (div_busy),
      .done       (div_done),
      .quot_a     (avg_t),
      .quot_b     (avg_g)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gas_thr_ff  <= tewa_pkg::GAS_THRESHOLD_RST;
         temp_thr_ff <= tewa_pkg::TEMP_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tewa_pkg::CSR_GAS_THRESHOLD:  gas_thr_ff  <= $signed(csr_wdata);
            tewa_pkg::CSR_TEMP_THRESHOLD: temp_thr_ff <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (last_acc) begin
               state_in = need_div ? ST_DIVIDE : ST_PUBLISH;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_PUBLISH && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in           = pend_ff;
      rsp_in.mean_temp = zero_avg_ff ? '0 : avg_t;
      rsp_in.mean_gas  = zero_avg_ff ? '0 : avg_g;
   end

   always_ff @(posedge clock) begin
      if (last_acc) begin
         pend_ff.event_found <= summary.found;
         pend_ff.start_index <= summary.start_idx;
         pend_ff.end_index   <= summary.end_idx;
         pend_ff.mean_temp   <= '0;
         pend_ff.mean_gas    <= '0;
         pend_ff.overrun     <= summary.overrun;
         zero_avg_ff         <= !need_div;
      end
      if (state_ff == ST_PUBLISH && slot_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_CLK(a_state_onehot, $onehot(state_ff))
   `ASSERT_NEXT(a_last_blocks_input, last_acc, !req_ready)
   `ASSERT_IMPL(a_div_done_in_divide, div_done, state_ff == ST_DIVIDE)
   `ASSERT_IMPL(a_divide_keeps_busy, state_ff == ST_DIVIDE && !div_done, div_busy)
   `ASSERT_IMPL(a_rsp_from_publish, $rose(rsp_valid_ff), $past(state_ff == ST_PUBLISH))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the threshold event window averager core. Sample
// items go in through a queue-fed driver with random gaps. A predictor keeps
// its own window state and builds the result each closing sample should give.
// The response side stalls at random, and once for a long stretch, and every
// result is checked field by field in order. Directed sets come first, then
// random sets under changing thresholds.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_GOAL = 390;

   // window states of the predictor
   localparam int WIN_IDLE   = 0;
   localparam int WIN_OPEN   = 1;
   localparam int WIN_CLOSED = 2;

   // value placement against a threshold
   localparam int REL_BELOW = 0;
   localparam int REL_EQUAL = 1;
   localparam int REL_ABOVE = 2;
   localparam int REL_ANY   = 3;

   // sample classes for set generation
   localparam int CLS_CALM  = 0;
   localparam int CLS_HOT   = 1;
   localparam int CLS_HOLD  = 2;
   localparam int CLS_QUIET = 3;
   localparam int CLS_NOISE = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_ready;
   tewa_pkg::req_item_type        req_item  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   tewa_pkg::rsp_item_type        rsp_item;
   logic                          csr_we    = 1'b0;
   tewa_pkg::csr_index_type       csr_index = tewa_pkg::CSR_GAS_THRESHOLD;
   logic [tewa_pkg::SAMPLE_W-1:0] csr_wdata = '0;

   tewa_pkg::req_item_type pending_samples[$];
   tewa_pkg::rsp_item_type window_summary_q[$];

   logic signed [tewa_pkg::SAMPLE_W-1:0] gas_thr  = tewa_pkg::GAS_THRESHOLD_RST;
   logic signed [tewa_pkg::SAMPLE_W-1:0] temp_thr = tewa_pkg::TEMP_THRESHOLD_RST;

   int     win_state = WIN_IDLE;
   int     set_count = 0;
   int     win_first = 0;
   int     win_stop  = 0;
   longint temp_acc  = 0;
   longint gas_acc   = 0;
   bit     over_cap  = 1'b0;

   int fault_count  = 0;
   int cycle_count  = 0;
   int random_items = 0;
   int req_gap      = 0;
   int rsp_wait     = 0;
   int hold_left    = 0;
   int hold_token   = 0;
   int hold_seen    = 0;
   bit sender_idle_on = 1'b1;
   bit recv_idle_on   = 1'b1;

   threshold_event_window_averager_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_fault(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fault_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_fault($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   task automatic fold_sample(input tewa_pkg::req_item_type s);
      int tv, gv, tt, gt, stop;
      longint len;
      tewa_pkg::rsp_item_type r;
      tv = $signed(s.temp_sample);
      gv = $signed(s.gas_sample);
      tt = temp_thr;
      gt = gas_thr;
      if (set_count < tewa_pkg::MAX_SAMPLES) begin
         if (win_state == WIN_IDLE) begin
            if (gv > gt || tv > tt) begin
               win_first = set_count;
               win_state = WIN_OPEN;
               temp_acc += tv;
               gas_acc  += gv;
            end
         end else if (win_state == WIN_OPEN) begin
            if (gv < gt && tv < tt) begin
               win_stop  = set_count;
               win_state = WIN_CLOSED;
            end else begin
               temp_acc += tv;
               gas_acc  += gv;
            end
         end
         set_count++;
      end else begin
         over_cap = 1'b1;
      end
      if (s.last_sample) begin
         r = '0;
         r.overrun = over_cap;
         if (win_state == WIN_IDLE) begin
            r.start_index = tewa_pkg::IDX_W'(set_count);
            r.end_index   = tewa_pkg::IDX_W'(set_count);
         end else begin
            stop = (win_state == WIN_OPEN) ? set_count : win_stop;
            len  = stop - win_first;
            r.event_found = 1'b1;
            r.start_index = tewa_pkg::IDX_W'(win_first);
            r.end_index   = tewa_pkg::IDX_W'(stop);
            if (len > 0) begin
               r.mean_temp = tewa_pkg::SAMPLE_W'(temp_acc / len);
               r.mean_gas  = tewa_pkg::SAMPLE_W'(gas_acc / len);
            end
         end
         window_summary_q.push_back(r);
         win_state = WIN_IDLE;
         set_count = 0;
         win_first = 0;
         win_stop  = 0;
         temp_acc  = 0;
         gas_acc   = 0;
         over_cap  = 1'b0;
      end
   endtask

   task automatic check_window_result(input tewa_pkg::rsp_item_type got);
      tewa_pkg::rsp_item_type want;
      if (window_summary_q.size() == 0) begin
         report_fault("result item with no set pending");
      end else begin
         want = window_summary_q.pop_front();
         check_field("event_found", got.event_found, want.event_found);
         check_field("start_index", got.start_index, want.start_index);
         check_field("end_index", got.end_index, want.end_index);
         check_field("mean_temp", $signed(got.mean_temp), $signed(want.mean_temp));
         check_field("mean_gas", $signed(got.mean_gas), $signed(want.mean_gas));
         check_field("overrun", got.overrun, want.overrun);
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready)
            fold_sample(req_item);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_item  <= pending_samples.pop_front();
               req_valid <= 1'b1;
               req_gap   <= sender_idle_on ? $urandom_range(0, 5) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_side
      int pause;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_window_result(rsp_item);
         if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= (hold_left == 1);
         end else if (rsp_valid && rsp_ready) begin
            pause = recv_idle_on ? $urandom_range(0, 5) : 0;
            rsp_wait  <= pause;
            rsp_ready <= (pause == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait  <= rsp_wait - 1;
            rsp_ready <= (rsp_wait == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [tewa_pkg::SAMPLE_W-1:0] pick_value(input int thr, input int rel);
      int room, v;
      v = thr;
      case (rel)
         REL_BELOW: begin
            room = thr + 32768;
            if (room > 0)
               v = ($urandom_range(0, 1) == 1) ? thr - $urandom_range(1, room < 4 ? room : 4)
                                               : -32768 + $urandom_range(0, room - 1);
         end
         REL_ABOVE: begin
            room = 32767 - thr;
            if (room > 0)
               v = ($urandom_range(0, 1) == 1) ? thr + $urandom_range(1, room < 4 ? room : 4)
                                               : 32767 - $urandom_range(0, room - 1);
         end
         REL_ANY: begin
            case ($urandom_range(0, 7))
               0:       v = -32768;
               1:       v = 32767;
               default: v = $urandom_range(0, 65535);
            endcase
         end
         default: v = thr;
      endcase
      return tewa_pkg::SAMPLE_W'(v);
   endfunction

   function automatic tewa_pkg::req_item_type sample_of(input int cls, input bit last);
      tewa_pkg::req_item_type s;
      int sel;
      sel = $urandom_range(0, 2);
      case (cls)
         CLS_CALM: begin
            s.temp_sample = pick_value(temp_thr, $urandom_range(0, 3) == 0 ? REL_EQUAL : REL_BELOW);
            s.gas_sample  = pick_value(gas_thr, $urandom_range(0, 3) == 0 ? REL_EQUAL : REL_BELOW);
         end
         CLS_HOT: begin
            s.temp_sample = pick_value(temp_thr, sel != 1 ? REL_ABOVE : REL_ANY);
            s.gas_sample  = pick_value(gas_thr, sel != 0 ? REL_ABOVE : REL_ANY);
         end
         CLS_HOLD: begin
            s.temp_sample = pick_value(temp_thr, sel != 1 ? REL_EQUAL : REL_BELOW);
            s.gas_sample  = pick_value(gas_thr, sel != 0 ? REL_EQUAL : REL_BELOW);
         end
         CLS_QUIET: begin
            s.temp_sample = pick_value(temp_thr, REL_BELOW);
            s.gas_sample  = pick_value(gas_thr, REL_BELOW);
         end
         default: begin
            s.temp_sample = pick_value(temp_thr, REL_ANY);
            s.gas_sample  = pick_value(gas_thr, REL_ANY);
         end
      endcase
      s.last_sample = last;
      return s;
   endfunction

   task automatic add_sample(input int t, input int g, input bit last);
      tewa_pkg::req_item_type s;
      s.temp_sample = tewa_pkg::SAMPLE_W'(t);
      s.gas_sample  = tewa_pkg::SAMPLE_W'(g);
      s.last_sample = last;
      pending_samples.push_back(s);
   endtask

   // quiet lead-in, event from a chosen sample, optional quiet close, then noise
   task automatic queue_set(input int n);
      int first, stop, cls;
      bit noisy;
      first = $urandom_range(0, n);
      stop  = first + $urandom_range(1, n - first + 1);
      noisy = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++) begin
         if (noisy || $urandom_range(0, 9) == 0)
            cls = CLS_NOISE;
         else if (i < first)
            cls = CLS_CALM;
         else if (i == first)
            cls = CLS_HOT;
         else if (i < stop)
            cls = ($urandom_range(0, 2) == 0) ? CLS_HOLD : CLS_HOT;
         else if (i == stop)
            cls = CLS_QUIET;
         else
            cls = CLS_NOISE;
         pending_samples.push_back(sample_of(cls, i == n - 1));
      end
      random_items += n;
   endtask

   task automatic write_threshold(input tewa_pkg::csr_index_type idx,
                                  input logic [tewa_pkg::SAMPLE_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == tewa_pkg::CSR_GAS_THRESHOLD)
         gas_thr = val;
      else
         temp_thr = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || window_summary_q.size() != 0);
      repeat (64) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_phase(input int goal);
      int mode, start;
      write_threshold(tewa_pkg::CSR_GAS_THRESHOLD, ($urandom_range(0, 2) == 0)
                      ? tewa_pkg::SAMPLE_W'($urandom)
                      : tewa_pkg::SAMPLE_W'($urandom_range(0, 6400)));
      write_threshold(tewa_pkg::CSR_TEMP_THRESHOLD, ($urandom_range(0, 2) == 0)
                      ? tewa_pkg::SAMPLE_W'($urandom)
                      : tewa_pkg::SAMPLE_W'($urandom_range(0, 3200) - 1600));
      @(negedge clock);
      mode = $urandom_range(0, 3);
      sender_idle_on = mode[0];
      recv_idle_on   = mode[1];
      start = random_items;
      while (random_items - start < goal)
         queue_set(($urandom_range(0, 7) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10));
      settle();
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("** threshold_event_window_averager_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int drain;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset thresholds: gas 200.0, temperature 95.0
      add_sample(100, 100, 1'b0);             // no event in set
      add_sample(1520, 3200, 1'b0);           // equal to both thresholds
      add_sample(-32768, -32768, 1'b1);
      add_sample(1521, 0, 1'b1);              // one-sample event on the last item
      add_sample(0, 0, 1'b1);                 // one quiet sample
      add_sample(0, 0, 1'b0);
      add_sample(0, 3201, 1'b0);              // gas opens the event
      add_sample(1520, 100, 1'b0);            // temperature at threshold keeps it open
      add_sample(100, 3200, 1'b0);            // gas at threshold keeps it open
      add_sample(1519, 3199, 1'b0);           // both below closes it
      add_sample(32767, 32767, 1'b0);         // ignored once closed
      add_sample(0, 0, 1'b1);
      add_sample(-11, 4000, 1'b0);            // negative mean truncates toward zero
      add_sample(0, 4000, 1'b1);
      add_sample(32767, -32768, 1'b0);        // full-scale values, event never closes
      add_sample(32767, 32767, 1'b0);
      add_sample(-32768, 32767, 1'b1);
      settle();

      write_threshold(tewa_pkg::CSR_GAS_THRESHOLD, 16'h8000);
      write_threshold(tewa_pkg::CSR_TEMP_THRESHOLD, 16'h7FFF);
      @(negedge clock);
      repeat (8) queue_set($urandom_range(1, 10));
      settle();

      write_threshold(tewa_pkg::CSR_GAS_THRESHOLD, 16'h7FFF);
      write_threshold(tewa_pkg::CSR_TEMP_THRESHOLD, 16'h8000);
      @(negedge clock);
      repeat (8) queue_set($urandom_range(1, 10));
      settle();

      // long receiver stall while short sets keep coming
      write_threshold(tewa_pkg::CSR_GAS_THRESHOLD, 16'h0000);
      write_threshold(tewa_pkg::CSR_TEMP_THRESHOLD, 16'h0000);
      @(negedge clock);
      sender_idle_on = 1'b0;
      recv_idle_on   = 1'b1;
      hold_token <= hold_token + 1;
      repeat (15) queue_set($urandom_range(1, 3));
      settle();

      while (random_items < RANDOM_GOAL)
         random_phase(60);

      write_threshold(tewa_pkg::CSR_GAS_THRESHOLD, tewa_pkg::GAS_THRESHOLD_RST);
      write_threshold(tewa_pkg::CSR_TEMP_THRESHOLD, tewa_pkg::TEMP_THRESHOLD_RST);
      @(negedge clock);
      sender_idle_on = 1'b1;
      recv_idle_on   = 1'b1;
      repeat (6) queue_set($urandom_range(1, 12));

      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid);
      drain = 0;
      while (window_summary_q.size() != 0 && drain < 4000) begin
         @(negedge clock);
         drain++;
      end
      repeat (80) @(posedge clock);
      if (window_summary_q.size() != 0)
         report_fault($sformatf("%0d results never arrived", window_summary_q.size()));

      if (fault_count == 0)
         $display("** threshold_event_window_averager_core: PASSED **");
      else
         $display("** threshold_event_window_averager_core: FAILED **");
      $finish;
   end

endmodule

// ===== threshold_event_window_averager_core.f =====
+incdir+design
design/tewa_pkg.sv
design/tewa_accum.sv
design/tewa_divider.sv
design/threshold_event_window_averager_core.sv
tb/tb_top.sv
